[rtl/core/esc_pkg.sv]
// Shared types and constants for the sensor compensation block.
// No dependencies; imported by every module of the block.
package esc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CAL      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_LOW  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_HIGH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_NINE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HUM_CAL        = 3'd4;

	localparam int DIV_STEPS = 32;
	localparam logic signed [31:0] HUM_CLAMP = 32'sd419430400;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] td;
		logic [19:0]        adc_p;
		logic [15:0]        adc_h;
	} item_t;

endpackage

[rtl/core/esc_front.sv]
// Input side: takes raw sample transactions and forms the first temperature terms.
// Depends on esc_pkg.
module esc_front import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	input  cal_t        cal,
	output logic        push,
	output item_t       push_item,
	input  logic        full
);

	logic  item_v_q;
	item_t item_q;
	logic signed [31:0] adc_t;
	logic signed [31:0] t1;

	assign adc_t = $signed({12'd0, s_tdata[19:0]});
	assign t1 = $signed({16'd0, cal.t1});
	assign s_tready = !item_v_q || !full;
	assign push = item_v_q && !full;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (s_tready) begin
			item_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q.tx <= (adc_t >>> 3) - (t1 <<< 1);
			item_q.td <= (adc_t >>> 4) - t1;
			item_q.adc_p <= s_tdata[39:20];
			item_q.adc_h <= s_tdata[55:40];
		end
	end

endmodule

[rtl/core/esc_queue.sv]
// Short queue between the input side and the arithmetic pipeline.
// Depends on esc_pkg for the item type.
module esc_queue import esc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

[rtl/core/esc_back.sv]
// Arithmetic pipeline: compensation terms, restoring divider and output register.
// Depends on esc_pkg.
module esc_back import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        empty,
	input  item_t       pop_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic        m_tuser
);

	logic en;
	logic signed [31:0] c_t2, c_t3, c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
	logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

	always_comb begin
		c_t2 = 32'($signed(cal.t2));
		c_t3 = 32'($signed(cal.t3));
		c_p1 = $signed({16'd0, cal.p1});
		c_p2 = 32'($signed(cal.p2));
		c_p3 = 32'($signed(cal.p3));
		c_p4 = 32'($signed(cal.p4));
		c_p5 = 32'($signed(cal.p5));
		c_p6 = 32'($signed(cal.p6));
		c_p7 = 32'($signed(cal.p7));
		c_p8 = 32'($signed(cal.p8));
		c_p9 = 32'($signed(cal.p9));
		c_h1 = $signed({24'd0, cal.h1});
		c_h2 = 32'($signed(cal.h2));
		c_h3 = $signed({24'd0, cal.h3});
		c_h4 = 32'($signed(cal.h4));
		c_h5 = 32'($signed(cal.h5));
		c_h6 = 32'($signed(cal.h6));
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_e1, v_e2, out_v_q;
	logic signed [31:0] m1_s1, dd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [15:0] adch_s1, adch_s2, adch_s3, adch_s4, adch_s5;
	logic signed [31:0] at_s2, m2_s2, fine_s3;
	logic signed [31:0] tm_s4, pa_s4, ha_s4, tt;
	logic [15:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_e1, temp_e2;
	logic signed [31:0] pd_s5, pm5_s5, pm2_s5, hm5_s5, hm6_s5, hm3_s5;
	logic signed [31:0] pb_s6, pm3_s6, pm5_s6, pm2_s6, hb_s6, hd2_s6;
	logic signed [31:0] pb2_s7, pa2_s7, hd3_s7, hb_s7;
	logic signed [31:0] pa3_s8, pp_s8, hm2_s8, hb_s8;
	logic signed [31:0] den_s9, pn_s9, hd4_s9, hb_s9;

	logic        dv_q    [DIV_STEPS+1];
	logic [31:0] dnum_q  [DIV_STEPS+1];
	logic [31:0] dden_q  [DIV_STEPS+1];
	logic [31:0] drem_q  [DIV_STEPS+1];
	logic [31:0] dquo_q  [DIV_STEPS+1];
	logic        dpost_q [DIV_STEPS+1];
	logic        dflt_q  [DIV_STEPS+1];
	logic [15:0] dtemp_q [DIV_STEPS+1];
	logic signed [31:0] dhm_q [DIV_STEPS+1];

	logic [31:0] pq;
	logic [31:0] pv_e1, sq_e1, pv_e2;
	logic signed [31:0] m8_e1, hsq_e1, hm_e1, pa9_e2, b8_e2, hs_e2, hm_e2;
	logic flt_e1, flt_e2;
	logic signed [31:0] hfin;
	logic [31:0] pfin;
	logic [15:0] temp_q;
	logic [31:0] press_q;
	logic [16:0] hum_q;
	logic        flt_q;

	assign en = !out_v_q || m_tready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			v_e1 <= 1'b0; v_e2 <= 1'b0; out_v_q <= 1'b0;
			for (int i = 0; i <= DIV_STEPS; i++) begin
				dv_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= !empty; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			dv_q[0] <= v_s9;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				dv_q[i] <= dv_q[i-1];
			end
			v_e1 <= dv_q[DIV_STEPS]; v_e2 <= v_e1; out_v_q <= v_e2;
		end
	end

	always_comb begin
		tt = (tm_s4 + 32'sd128) >>> 8;
		pq = dpost_q[DIV_STEPS] ? {dquo_q[DIV_STEPS][30:0], 1'b0} : dquo_q[DIV_STEPS];
		hfin = hm_e2 - (hs_e2 >>> 4);
		pfin = pv_e2 + 32'(((pa9_e2 >>> 12) + b8_e2 + c_p7) >>> 4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= pop_item.tx * c_t2;
			dd_s1 <= pop_item.td * pop_item.td;
			adcp_s1 <= pop_item.adc_p;
			adch_s1 <= pop_item.adc_h;

			at_s2 <= m1_s1 >>> 11;
			m2_s2 <= (dd_s1 >>> 12) * c_t3;
			adcp_s2 <= adcp_s1; adch_s2 <= adch_s1;

			fine_s3 <= at_s2 + (m2_s2 >>> 14);
			adcp_s3 <= adcp_s2; adch_s3 <= adch_s2;

			tm_s4 <= fine_s3 * 32'sd5;
			pa_s4 <= (fine_s3 >>> 1) - 32'sd64000;
			ha_s4 <= fine_s3 - 32'sd76800;
			adcp_s4 <= adcp_s3; adch_s4 <= adch_s3;

			if (tt > 32'sd32767) begin
				temp_s5 <= 16'h7fff;
			end else if (tt < -32'sd32768) begin
				temp_s5 <= 16'h8000;
			end else begin
				temp_s5 <= tt[15:0];
			end
			pd_s5 <= (pa_s4 >>> 2) * (pa_s4 >>> 2);
			pm5_s5 <= pa_s4 * c_p5;
			pm2_s5 <= c_p2 * pa_s4;
			hm5_s5 <= c_h5 * ha_s4;
			hm6_s5 <= ha_s4 * c_h6;
			hm3_s5 <= ha_s4 * c_h3;
			adcp_s5 <= adcp_s4; adch_s5 <= adch_s4;

			pb_s6 <= (pd_s5 >>> 11) * c_p6;
			pm3_s6 <= c_p3 * (pd_s5 >>> 13);
			pm5_s6 <= pm5_s5; pm2_s6 <= pm2_s5;
			hb_s6 <= ($signed({2'd0, adch_s5, 14'd0}) - (c_h4 <<< 20)
				- hm5_s5 + 32'sd16384) >>> 15;
			hd2_s6 <= (hm6_s5 >>> 10) * ((hm3_s5 >>> 11) + 32'sd32768);
			temp_s6 <= temp_s5; adcp_s6 <= adcp_s5;

			pb2_s7 <= ((pb_s6 + (pm5_s6 <<< 1)) >>> 2) + (c_p4 <<< 16);
			pa2_s7 <= ((pm3_s6 >>> 3) + (pm2_s6 >>> 1)) >>> 18;
			hd3_s7 <= (hd2_s6 >>> 10) + 32'sd2097152;
			hb_s7 <= hb_s6; temp_s7 <= temp_s6; adcp_s7 <= adcp_s6;

			pa3_s8 <= (32'sd32768 + pa2_s7) * c_p1;
			pp_s8 <= 32'sd1048576 - $signed({12'd0, adcp_s7}) - (pb2_s7 >>> 12);
			hm2_s8 <= hd3_s7 * c_h2;
			hb_s8 <= hb_s7; temp_s8 <= temp_s7;

			den_s9 <= pa3_s8 >>> 15;
			pn_s9 <= pp_s8 * 32'sd3125;
			hd4_s9 <= (hm2_s8 + 32'sd8192) >>> 14;
			hb_s9 <= hb_s8; temp_s9 <= temp_s8;

			dnum_q[0] <= pn_s9[31] ? pn_s9 : {pn_s9[30:0], 1'b0};
			dpost_q[0] <= pn_s9[31];
			dden_q[0] <= den_s9;
			dflt_q[0] <= den_s9 == 32'sd0;
			drem_q[0] <= '0;
			dquo_q[0] <= '0;
			dhm_q[0] <= hb_s9 * hd4_s9;
			dtemp_q[0] <= temp_s9;

			for (int i = 1; i <= DIV_STEPS; i++) begin
				logic [32:0] trial;
				trial = {drem_q[i-1], dnum_q[i-1][31]};
				if (trial >= {1'b0, dden_q[i-1]}) begin
					drem_q[i] <= 32'(trial - {1'b0, dden_q[i-1]});
					dquo_q[i] <= {dquo_q[i-1][30:0], 1'b1};
				end else begin
					drem_q[i] <= trial[31:0];
					dquo_q[i] <= {dquo_q[i-1][30:0], 1'b0};
				end
				dnum_q[i] <= {dnum_q[i-1][30:0], 1'b0};
				dden_q[i] <= dden_q[i-1];
				dpost_q[i] <= dpost_q[i-1];
				dflt_q[i] <= dflt_q[i-1];
				dhm_q[i] <= dhm_q[i-1];
				dtemp_q[i] <= dtemp_q[i-1];
			end

			pv_e1 <= pq;
			sq_e1 <= {3'd0, pq[31:3]} * {3'd0, pq[31:3]};
			m8_e1 <= $signed({2'd0, pq[31:2]}) * c_p8;
			hsq_e1 <= (dhm_q[DIV_STEPS] >>> 15) * (dhm_q[DIV_STEPS] >>> 15);
			hm_e1 <= dhm_q[DIV_STEPS];
			flt_e1 <= dflt_q[DIV_STEPS];
			temp_e1 <= dtemp_q[DIV_STEPS];

			pa9_e2 <= c_p9 * $signed({13'd0, sq_e1[31:13]});
			b8_e2 <= m8_e1 >>> 13;
			hs_e2 <= (hsq_e1 >>> 7) * c_h1;
			pv_e2 <= pv_e1; hm_e2 <= hm_e1; flt_e2 <= flt_e1; temp_e2 <= temp_e1;

			temp_q <= temp_e2;
			press_q <= flt_e2 ? '0 : pfin;
			flt_q <= flt_e2;
			if (hfin < 32'sd0) begin
				hum_q <= '0;
			end else if (hfin > HUM_CLAMP) begin
				hum_q <= HUM_CLAMP[28:12];
			end else begin
				hum_q <= hfin[28:12];
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {7'd0, hum_q, press_q, temp_q};
	assign m_tuser = flt_q;

`ifndef SYNTH
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[47:16] == 32'd0))
		else $error("fault result carries nonzero pressure");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[64:48] <= 17'd102400))
		else $error("humidity beyond full scale");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_q[DIV_STEPS] && dden_q[DIV_STEPS] != 32'd0) |->
		(drem_q[DIV_STEPS] < dden_q[DIV_STEPS]))
		else $error("divider remainder not below divisor");
`endif

endmodule

[rtl/core/env_sensor_compensation.sv]
// Sensor compensation top level: configuration registers, input side, queue, pipeline.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
//
// Usage: s_* carries one transaction per raw burst, tdata = raw_temperature [19:0],
// raw_pressure [39:20], raw_humidity [55:40]. m_* returns one transaction per burst,
// tdata = temperature_centi [15:0], pressure_pa [47:16], humidity_q10 [64:48];
// tuser = divide_fault. cfg_* writes calibration words, index 0..4 in the order
// temp_cal, press_cal_low, press_cal_high, press_cal_nine, hum_cal; cfg_ready is
// always high and other indexes are ignored. Write calibration only while idle.
// Throughput: one transaction per cycle while the output is not stalled, set by the fully
// pipelined datapath and the 32-stage restoring divider (one quotient bit per stage).
// Path from input acceptance to m_tvalid: the input register loads at the accepting
// edge, then queue, 9 arithmetic stages, 33 divider stages, 3 tail stages.
// Reset clears all calibration words and empties every stage. When m_tready is low while
// a result waits at the output, the whole pipeline holds; the queue and input register
// keep accepting up to QUEUE_DEPTH + 1 further transactions before s_tready drops.
module env_sensor_compensation import esc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [55:0]            s_tdata,   // raw_temperature, raw_pressure, raw_humidity
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [71:0]            m_tdata,   // temperature_centi, pressure_pa, humidity_q10
	output logic                   m_tuser,   // divide_fault
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_low_q, press_high_q, hum_cal_q;
	logic [15:0] press_nine_q;
	cal_t  cal;
	logic  push, full, pop, empty;
	item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_low_q <= '0;
			press_high_q <= '0;
			press_nine_q <= '0;
			hum_cal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TEMP_CAL: temp_cal_q <= cfg_data[47:0];
				CFG_PRESS_CAL_LOW: press_low_q <= cfg_data;
				CFG_PRESS_CAL_HIGH: press_high_q <= cfg_data;
				CFG_PRESS_CAL_NINE: press_nine_q <= cfg_data[15:0];
				CFG_HUM_CAL: hum_cal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = temp_cal_q[15:0];
		cal.t2 = temp_cal_q[31:16];
		cal.t3 = temp_cal_q[47:32];
		cal.p1 = press_low_q[15:0];
		cal.p2 = press_low_q[31:16];
		cal.p3 = press_low_q[47:32];
		cal.p4 = press_low_q[63:48];
		cal.p5 = press_high_q[15:0];
		cal.p6 = press_high_q[31:16];
		cal.p7 = press_high_q[47:32];
		cal.p8 = press_high_q[63:48];
		cal.p9 = press_nine_q;
		cal.h1 = hum_cal_q[7:0];
		cal.h2 = hum_cal_q[23:8];
		cal.h3 = hum_cal_q[31:24];
		cal.h4 = hum_cal_q[43:32];
		cal.h5 = hum_cal_q[55:44];
		cal.h6 = hum_cal_q[63:56];
	end

	esc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cal       (cal),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	esc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	esc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal),
		.empty    (empty),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
